// ----- rtl/core/octave_gradient_noise_2d_defines.svh -----
// assertion macros for the octave gradient noise block
// expects i_clk and i_rst_n in the scope of use
`ifndef OCTAVE_GRADIENT_NOISE_2D_DEFINES_SVH
`define OCTAVE_GRADIENT_NOISE_2D_DEFINES_SVH

// same-cycle implication
`define OGN_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("ogn check failed");

// next-cycle implication
`define OGN_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ogn check failed");

`endif

// ----- rtl/core/ogn_pkg.sv -----
// shared types, constants and direction rom for the octave gradient noise block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ogn_pkg;

    localparam int TBL_AW   = 8;
    localparam int MAX_OCT  = 8;
    localparam int CW       = 23;
    localparam int OSW      = 24;
    localparam int TW       = 28;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [4:0]  DIV_LAST = 5'd22;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic CFG_BASE_PERIOD  = 1'b0;
    localparam logic CFG_OCTAVE_COUNT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_DIV,
        S_WGT,
        S_CORNER,
        S_OCT,
        S_DONE
    } t_state;

    localparam logic [15:0] QSINE [0:64] = '{
        16'd0, 16'd804, 16'd1608, 16'd2411, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
        16'd6393, 16'd7180, 16'd7962, 16'd8740, 16'd9512, 16'd10279, 16'd11039,
        16'd11793, 16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151,
        16'd16846, 16'd17531, 16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788,
        16'd21403, 16'd22006, 16'd22595, 16'd23170, 16'd23732, 16'd24279, 16'd24812,
        16'd25330, 16'd25833, 16'd26320, 16'd26791, 16'd27246, 16'd27684, 16'd28106,
        16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957, 16'd30274, 16'd30572,
        16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972, 16'd32138,
        16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
        16'd32767
    };

    // sine in 256ths of a turn, q1.15
    function automatic logic signed [15:0] f_sine(input logic [7:0] a);
        logic [6:0] r;
        logic [6:0] rm;
        r  = {1'b0, a[5:0]};
        rm = 7'd64 - r;
        unique case (a[7:6])
            2'd0: f_sine = QSINE[r];
            2'd1: f_sine = QSINE[rm];
            2'd2: f_sine = -QSINE[r];
            default: f_sine = -QSINE[rm];
        endcase
    endfunction

    function automatic logic signed [15:0] f_cosine(input logic [7:0] a);
        f_cosine = f_sine(a + 8'd64);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/octave_gradient_noise_2d.sv -----
// octave-summed 2d gradient noise, shared multiplier under a step sequencer
// depends on ogn_pkg and octave_gradient_noise_2d_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "octave_gradient_noise_2d_defines.svh"
// each octave is one pass of the sequencer, in which the 23-step remainder unit runs
// twice; busy drops with the result strobe, so a query can be taken in the strobe cycle
// a table write keeps busy low; the result shows for one cycle
// reset: synchronous active low, clears sequencer, strobe and config registers
// (base period 256, four octaves); the permutation table keeps its contents
module octave_gradient_noise_2d (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_action,
    input  wire logic [7:0]           i_table_index,
    input  wire logic [7:0]           i_table_value,
    input  wire logic [31:0]          i_x_coord,
    input  wire logic [31:0]          i_y_coord,
    output logic                      o_valid,
    output logic signed [19:0]        o_noise_value,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);
    import ogn_pkg::*;

    t_state r_state, n_state;

    logic [15:0]             r_base_period;
    logic [3:0]              r_octave_count;
    logic [7:0]              r_perm [0:255];
    logic [7:0]              r_pdat;
    logic [7:0]              r_p1;
    logic [7:0]              rd_addr;

    logic [31:0]             r_x, r_y;
    logic [3:0]              r_octs;
    logic [3:0]              r_k;
    logic [2:0]              r_ph;
    logic [1:0]              r_sel;
    logic [4:0]              r_cnt;
    logic [CW-1:0]           r_dq, r_iy, r_per, r_rem;
    logic [15:0]             r_fx, r_fy;
    logic [7:0]              r_rx [0:1];
    logic [7:0]              r_ry [0:1];
    logic [16:0]             r_wx [0:1];
    logic [16:0]             r_wy [0:1];
    logic [19:0]             r_q;
    logic [16:0]             r_wxy;
    logic signed [33:0]      r_dot;
    logic signed [52:0]      r_prod;
    logic signed [OSW-1:0]   r_osum;
    logic signed [TW-1:0]    r_total;
    logic                    r_valid;
    logic signed [19:0]      r_noise;

    logic                    accept;
    logic [3:0]              octs_in;
    logic [15:0]             p0;
    logic [38:0]             sx, sy;
    logic [CW:0]             rem_sh, rem_nx, rem_inc;
    logic [16:0]             d;
    logic [35:0]             six;
    logic [21:0]             q_nx;
    logic [20:0]             fade;
    logic [16:0]             w_nx;
    logic                    cx, cy;
    logic signed [16:0]      ox, oy;
    logic signed [15:0]      g_cos, g_sin;
    logic signed [34:0]      mul_a;
    logic signed [17:0]      mul_b;
    logic signed [TW-1:0]    oct_add;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign octs_in = (r_octave_count > 4'(MAX_OCT)) ? 4'(MAX_OCT) : r_octave_count;
    assign p0      = (r_base_period == 16'd0) ? 16'd1 : r_base_period;
    assign cx      = r_sel[0];
    assign cy      = r_sel[1];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_period  <= 16'd256;
            r_octave_count <= 4'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_PERIOD:  r_base_period  <= i_cfg_data;
                CFG_OCTAVE_COUNT: r_octave_count <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // permutation table, registered read
    always_comb begin
        unique case (r_ph)
            3'd0:    rd_addr = r_rx[cx];
            3'd1:    rd_addr = r_pdat + r_ry[cy];
            default: rd_addr = r_p1 + r_ry[cy];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_action == ACT_WRITE) begin
            r_perm[i_table_index] <= i_table_value;
        end
        r_pdat <= r_perm[rd_addr];
    end

    // scaled coordinates and remainder step
    assign sx      = {7'd0, r_x} << r_k[2:0];
    assign sy      = {7'd0, r_y} << r_k[2:0];
    assign rem_sh  = {r_rem, r_dq[CW-1]};
    assign rem_nx  = (rem_sh >= {1'b0, r_per}) ? rem_sh - {1'b0, r_per} : rem_sh;
    assign rem_inc = rem_nx + (CW+1)'(1);

    // weight arithmetic
    always_comb begin
        unique case (r_sel)
            2'd0: d = {1'b0, r_fx};
            2'd1: d = ONE_Q16 - {1'b0, r_fx};
            2'd2: d = {1'b0, r_fy};
            default: d = ONE_Q16 - {1'b0, r_fy};
        endcase
    end
    assign six  = {1'b0, r_prod[32:0], 2'b00} + {2'b00, r_prod[32:0], 1'b0};
    assign q_nx = {2'b00, six[35:16]} + 22'd655360 - ({1'b0, d, 4'd0} - {5'd0, d});
    assign fade = r_prod[36:16];
    assign w_nx = (fade > {4'd0, ONE_Q16}) ? 17'd0 : ONE_Q16 - fade[16:0];

    // corner offsets and gradient
    assign ox    = cx ? $signed({1'b1, r_fx}) : $signed({1'b0, r_fx});
    assign oy    = cy ? $signed({1'b1, r_fy}) : $signed({1'b0, r_fy});
    assign g_cos = f_cosine(r_pdat);
    assign g_sin = f_sine(r_pdat);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_WGT) begin
            unique case (r_ph)
                3'd0: begin
                    mul_a = $signed({18'd0, d});
                    mul_b = $signed({1'b0, d});
                end
                3'd1: begin
                    mul_a = $signed({18'd0, r_prod[32:16]});
                    mul_b = $signed({1'b0, d});
                end
                3'd2: begin
                    mul_a = $signed({15'd0, r_q});
                    mul_b = $signed({1'b0, r_prod[32:16]});
                end
                default: ;
            endcase
        end else if (r_state == S_CORNER) begin
            unique case (r_ph)
                3'd1: begin
                    mul_a = $signed({18'd0, r_wx[cx]});
                    mul_b = $signed({1'b0, r_wy[cy]});
                end
                3'd2: begin
                    mul_a = 35'(ox);
                    mul_b = 18'(g_cos);
                end
                3'd3: begin
                    mul_a = 35'(oy);
                    mul_b = 18'(g_sin);
                end
                3'd5: begin
                    mul_a = 35'(r_dot);
                    mul_b = $signed({1'b0, r_wxy});
                end
                default: ;
            endcase
        end
    end

    assign oct_add = TW'(r_osum >>> r_k[2:0]);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_action == ACT_QUERY) begin
                    n_state = (octs_in == 4'd0) ? S_DONE : S_SCALE;
                end
            end
            S_SCALE: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == DIV_LAST && r_sel[0]) n_state = S_WGT;
            end
            S_WGT: begin
                if (r_ph == 3'd3 && r_sel == 2'd3) n_state = S_CORNER;
            end
            S_CORNER: begin
                if (r_ph == 3'd6 && r_sel == 2'd3) n_state = S_OCT;
            end
            S_OCT:  n_state = (r_k + 4'd1 == r_octs) ? S_DONE : S_SCALE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= 53'(mul_a * mul_b);
        unique case (r_state)
            S_IDLE: begin
                r_x     <= i_x_coord;
                r_y     <= i_y_coord;
                r_octs  <= octs_in;
                r_k     <= 4'd0;
                r_total <= '0;
            end
            S_SCALE: begin
                r_dq   <= sx[38:16];
                r_iy   <= sy[38:16];
                r_fx   <= sx[15:0];
                r_fy   <= sy[15:0];
                r_per  <= CW'({7'd0, p0} << r_k[2:0]);
                r_rem  <= '0;
                r_cnt  <= '0;
                r_sel  <= '0;
                r_ph   <= '0;
                r_osum <= '0;
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    // remainders of ix and of ix + 1, then of iy and of iy + 1
                    if (!r_sel[0]) begin
                        r_rx[0] <= rem_nx[7:0];
                        r_rx[1] <= (rem_inc == {1'b0, r_per}) ? 8'd0 : rem_inc[7:0];
                        r_dq    <= r_iy;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_sel   <= 2'd1;
                    end else begin
                        r_ry[0] <= rem_nx[7:0];
                        r_ry[1] <= (rem_inc == {1'b0, r_per}) ? 8'd0 : rem_inc[7:0];
                        r_sel   <= 2'd0;
                        r_ph    <= 3'd0;
                    end
                end else begin
                    r_rem <= rem_nx[CW-1:0];
                    r_dq  <= {r_dq[CW-2:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            S_WGT: begin
                if (r_ph == 3'd1) begin
                    r_q <= q_nx[19:0];
                end
                if (r_ph == 3'd3) begin
                    if (!r_sel[1]) r_wx[r_sel[0]] <= w_nx;
                    else           r_wy[r_sel[0]] <= w_nx;
                    r_sel <= r_sel + 2'd1;
                    r_ph  <= 3'd0;
                end else begin
                    r_ph <= r_ph + 3'd1;
                end
            end
            S_CORNER: begin
                unique case (r_ph)
                    3'd1: r_p1  <= r_pdat;
                    3'd2: r_wxy <= r_prod[32:16];
                    3'd3: r_dot <= r_prod[33:0];
                    3'd4: r_dot <= r_dot + r_prod[33:0];
                    3'd6: r_osum <= r_osum + OSW'($signed(r_prod[52:31]));
                    default: ;
                endcase
                if (r_ph == 3'd6) begin
                    r_ph  <= 3'd0;
                    r_sel <= r_sel + 2'd1;
                end else begin
                    r_ph <= r_ph + 3'd1;
                end
            end
            S_OCT: begin
                r_total <= r_total + oct_add;
                r_k     <= r_k + 4'd1;
            end
            default: ;
        endcase
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_DONE);
        end
        if (r_total > TW'(524287))       r_noise <= 20'sd524287;
        else if (r_total < -TW'(524288)) r_noise <= -20'sd524288;
        else                             r_noise <= r_total[19:0];
    end

    assign o_valid       = r_valid;
    assign o_noise_value = r_noise;

    `OGN_ASSERT_NEXT(a_done_strobes, r_state == S_DONE, o_valid)
    `OGN_ASSERT_NOW(a_strobe_idle, o_valid, !busy)
    `OGN_ASSERT_NEXT(a_query_busy, accept && i_action == ACT_QUERY, busy)
    `OGN_ASSERT_NEXT(a_write_free, accept && i_action == ACT_WRITE, !busy)
    `OGN_ASSERT_NOW(a_rem_bound, r_state == S_DIV, r_rem < r_per)

endmodule
`default_nettype wire

// ----- bench/octave_gradient_noise_2d_tb.sv -----
// testbench for octave_gradient_noise_2d: table writes and noise queries checked
// against an in-bench predictor; depends on ogn_pkg and the block itself
`timescale 1ns / 1ps
module octave_gradient_noise_2d_tb;
    import ogn_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 800;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_action;
    logic [7:0]         i_table_index;
    logic [7:0]         i_table_value;
    logic [31:0]        i_x_coord;
    logic [31:0]        i_y_coord;
    logic               o_valid;
    logic signed [19:0] o_noise_value;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [15:0]        i_cfg_data;

    octave_gradient_noise_2d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_table_index(i_table_index),
        .i_table_value(i_table_value), .i_x_coord(i_x_coord), .i_y_coord(i_y_coord),
        .o_valid(o_valid), .o_noise_value(o_noise_value),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [7:0]         perm_copy [0:255];
    logic [15:0]        period_reg;
    logic [3:0]         octaves_reg;
    logic signed [19:0] noise_expected [$];

    int sender_idle_pct;
    int mismatch_count;
    int checked_count;
    int query_count;
    int write_count;
    int idle_cycles;
    bit timed_out;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sine_256(input logic [7:0] a);
        longint r;
        r = a[5:0];
        case (a[7:6])
            2'd0: return longint'(QSINE[r]);
            2'd1: return longint'(QSINE[64 - r]);
            2'd2: return -longint'(QSINE[r]);
            default: return -longint'(QSINE[64 - r]);
        endcase
    endfunction

    // 1 - quintic fade, q16
    function automatic longint corner_weight(input longint d);
        longint q, t2, t3, fd;
        q  = ((6 * d * d) >> 16) + 10 * 65536 - 15 * d;
        t2 = (d * d) >> 16;
        t3 = (t2 * d) >> 16;
        fd = (t3 * q) >> 16;
        if (fd > 65536) fd = 65536;
        return 65536 - fd;
    endfunction

    function automatic logic signed [19:0] predict_noise(input logic [31:0] x,
                                                         input logic [31:0] y);
        longint total, osum, sx, sy, per, ix, iy, fx, fy, ox, oy, wxy, dot, p1;
        longint gx, gy;
        int octs;
        logic [7:0] h;
        total = 0;
        octs  = (octaves_reg > MAX_OCT) ? MAX_OCT : int'(octaves_reg);
        for (int k = 0; k < octs; k++) begin
            sx  = longint'(x) << k;
            sy  = longint'(y) << k;
            per = longint'((period_reg == 0) ? 16'd1 : period_reg) << k;
            ix  = sx >> 16;
            iy  = sy >> 16;
            fx  = sx & 64'hFFFF;
            fy  = sy & 64'hFFFF;
            osum = 0;
            for (int cy = 0; cy < 2; cy++) begin
                for (int cx = 0; cx < 2; cx++) begin
                    gx  = ix + cx;
                    gy  = iy + cy;
                    ox  = cx ? fx - 65536 : fx;
                    oy  = cy ? fy - 65536 : fy;
                    wxy = (corner_weight(cx ? 65536 - fx : fx)
                           * corner_weight(cy ? 65536 - fy : fy)) >> 16;
                    p1  = perm_copy[(gx % per) % 256];
                    h   = perm_copy[(p1 + gy % per) % 256];
                    dot = ox * sine_256(h + 8'd64) + oy * sine_256(h);
                    osum += (wxy * dot) >>> 31;
                end
            end
            total += osum >>> k;
        end
        if (total > 524287) total = 524287;
        if (total < -524288) total = -524288;
        return total[19:0];
    endfunction

    // one word in; expectation is recorded at the accepting edge
    task automatic send_word(input logic act, input logic [7:0] idx,
                             input logic [7:0] val, input logic [31:0] x,
                             input logic [31:0] y);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 40 : 4)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_table_index <= idx;
        i_table_value <= val;
        i_x_coord     <= x;
        i_y_coord     <= y;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        if (act == ACT_WRITE) begin
            perm_copy[idx] = val;
            write_count++;
        end else begin
            noise_expected = {noise_expected, predict_noise(x, y)};
            query_count++;
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (noise_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_BASE_PERIOD) period_reg = data;
        else octaves_reg = data[3:0];
    endtask

    task automatic query(input logic [31:0] x, input logic [31:0] y);
        send_word(ACT_QUERY, 8'($urandom), 8'($urandom), x, y);
    endtask

    // every entry written before any query reads the table
    task automatic test_table_fill();
        send_word(ACT_WRITE, 8'd0, 8'd255, $urandom, $urandom);
        for (int i = 1; i < 255; i++)
            send_word(ACT_WRITE, i[7:0], 8'($urandom), $urandom, $urandom);
        send_word(ACT_WRITE, 8'd255, 8'd0, $urandom, $urandom);
    endtask

    task automatic test_directed();
        query(32'h0, 32'h0);
        query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        query(32'h0001_0000, 32'h0003_0000);
        query(32'h0000_8000, 32'h0000_8000);
        query(32'h00FF_FFFF, 32'h0000_0001);
        write_reg(CFG_OCTAVE_COUNT, 16'd8);
        query(32'hFFFF_FFFF, 32'h0);
        query(32'h1234_5678, 32'h9ABC_DEF0);
        write_reg(CFG_OCTAVE_COUNT, 16'd1);
        query(32'h0000_4000, 32'h0000_C000);
        // zero octaves and counts past the maximum
        write_reg(CFG_OCTAVE_COUNT, 16'd0);
        query(32'h0005_1234, 32'h0007_4321);
        write_reg(CFG_OCTAVE_COUNT, 16'hFFFF);
        query(32'h0005_1234, 32'h0007_4321);
        // zero period acts as one, then the extremes
        write_reg(CFG_OCTAVE_COUNT, 16'd3);
        write_reg(CFG_BASE_PERIOD, 16'd0);
        query(32'h0005_1234, 32'h0007_4321);
        write_reg(CFG_BASE_PERIOD, 16'd1);
        query(32'h00FF_8000, 32'h0001_7FFF);
        write_reg(CFG_BASE_PERIOD, 16'hFFFF);
        query(32'hFFFF_0000, 32'hFFFE_FFFF);
        send_word(ACT_WRITE, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_WRITE, 8'd0, 8'd0, 32'h0, 32'h0);
        query(32'h0000_0000, 32'h00FF_0000);
        write_reg(CFG_BASE_PERIOD, 16'd256);
        write_reg(CFG_OCTAVE_COUNT, 16'd4);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return {16'($urandom_range(15)), 16'h0000};
            1: return {16'($urandom), 16'h0000};
            2: return {8'h00, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_config();
        logic [15:0] per;
        logic [15:0] octs;
        case ($urandom_range(7))
            0: per = 16'hFFFF;
            1: per = 16'd1;
            2: per = 16'd0;
            3: per = 16'd256;
            default: per = 16'($urandom_range(1, 600));
        endcase
        case ($urandom_range(9))
            0: octs = 16'd8;
            1: octs = 16'd0;
            2: octs = {12'($urandom), 4'($urandom_range(9, 15))};
            default: octs = {12'($urandom), 4'($urandom_range(1, 4))};
        endcase
        write_reg(CFG_BASE_PERIOD, per);
        write_reg(CFG_OCTAVE_COUNT, octs);
    endtask

    task automatic test_random(input int n_words);
        for (int i = 0; i < n_words; i++) begin
            if (i % 90 == 0) random_config();
            if ($urandom_range(99) < 15)
                send_word(ACT_WRITE, 8'($urandom), 8'($urandom), $urandom, $urandom);
            else
                query(rand_coord(), rand_coord());
        end
    endtask

    // result checker, sampled mid-cycle
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (noise_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected noise word %0d", o_noise_value);
            end else begin
                if (o_noise_value !== noise_expected[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: noise expected %0d got %0d",
                                 noise_expected[0], o_noise_value);
                end
                void'(noise_expected.pop_front());
                checked_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        timed_out = 1'b0;
        wait (idle_cycles >= WATCHDOG_LIMIT);
        timed_out = 1'b1;
        $display("ERROR: watchdog expired with %0d words outstanding",
                 noise_expected.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        start = 1'b0; i_action = ACT_WRITE; i_table_index = '0; i_table_value = '0;
        i_x_coord = '0; i_y_coord = '0;
        i_cfg_we = 1'b0; i_cfg_index = CFG_BASE_PERIOD; i_cfg_data = '0;
        i_rst_n = 1'b0;
        idle_cycles = 0; mismatch_count = 0; checked_count = 0;
        query_count = 0; write_count = 0;
        period_reg = 16'd256; octaves_reg = 4'd4;
        sender_idle_pct = 15;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_fill();
        test_directed();
        test_random(550);
        sender_idle_pct = 82;
        test_random(550);
        sender_idle_pct = 0;
        test_random(550);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d queries and %0d table writes, %0d results checked",
                 query_count, write_count, checked_count);
        $display("periods 0 to 65535, octave counts 0 to 15, mismatches %0d",
                 mismatch_count);
        if (mismatch_count == 0 && noise_expected.size() == 0 && !timed_out)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- octave_gradient_noise_2d.f -----
+incdir+rtl/core
rtl/core/ogn_pkg.sv
rtl/core/octave_gradient_noise_2d.sv
bench/octave_gradient_noise_2d_tb.sv
